// ===== rtl/tile_nd_source_address_assert.svh =====
// Assertion macros for the tiled source address generator.
`ifndef TILE_ND_SOURCE_ADDRESS_ASSERT_SVH
`define TILE_ND_SOURCE_ADDRESS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TNSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tile_nd_source_address assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TNSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tile_nd_source_address assertion failed");

`endif

// ===== rtl/tnsa_pkg.sv =====
// Types and constants for the tiled source address generator.
`timescale 1ns / 1ps
`default_nettype none
package tnsa_pkg;
  localparam int DIMS    = 4;
  localparam int IDX_W   = 32;
  localparam int EXT_W   = 16;
  localparam int TILE_W  = 8;
  localparam int OEXT_W  = EXT_W + TILE_W;
  localparam int CFG_W   = 3;
  localparam int DIM_W   = 2;

  localparam logic [CFG_W-1:0] CFG_EXT_0  = 3'd0;
  localparam logic [CFG_W-1:0] CFG_TILE_0 = 3'd4;

  localparam int DIV_STG = IDX_W;
  localparam int MOD_STG = TILE_W;
  localparam int DIM_STG = DIV_STG + MOD_STG + 1;
  localparam int N_STG   = DIMS * DIM_STG;

  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  num;
    logic [OEXT_W-1:0] rem;
    logic [IDX_W-1:0]  off;
  } stg_t;
endpackage
`default_nettype wire

// ===== rtl/tile_nd_source_address.sv =====
// Tiled tensor source address generator: index split, wrap and restride.
// Throughput: one word per cycle unless a valid output is stalled; one stage per quotient
// bit of each per-dimension divider, one per wrap bit, one multiply stage per dimension.
// A stalled output holds the whole pipeline.
// Synchronous active-low reset: extents and tile counts return to 1, no words in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "tile_nd_source_address_assert.svh"
module tile_nd_source_address (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [tnsa_pkg::IDX_W-1:0]    in_out_index,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [tnsa_pkg::IDX_W-1:0]    out_source_offset,
  output      logic                          out_out_of_range,
  input  wire logic                          cfg_we,
  input  wire logic [tnsa_pkg::CFG_W-1:0]    cfg_index,
  input  wire logic [tnsa_pkg::EXT_W-1:0]    cfg_data
);
  localparam int NS = tnsa_pkg::N_STG;

  logic [tnsa_pkg::EXT_W-1:0]  ext_r  [tnsa_pkg::DIMS];
  logic [tnsa_pkg::TILE_W-1:0] tile_r [tnsa_pkg::DIMS];
  logic [tnsa_pkg::OEXT_W-1:0] oext_r [tnsa_pkg::DIMS];
  logic [tnsa_pkg::IDX_W-1:0]  p23_r;
  logic [tnsa_pkg::IDX_W-1:0]  str0_r;
  logic [tnsa_pkg::IDX_W-1:0]  stride [tnsa_pkg::DIMS];
  logic                        zero_r;
  logic                        zero_nxt;

  tnsa_pkg::stg_t s_r [0:NS];
  tnsa_pkg::stg_t stg_nxt [1:NS];

  logic                        en;
  logic                        out_valid_r;
  logic [tnsa_pkg::IDX_W-1:0]  out_off_r;
  logic                        out_oor_r;
  logic                        oor_nxt;
  logic [tnsa_pkg::CFG_W-1:0]  tidx;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign tidx     = cfg_index - tnsa_pkg::CFG_TILE_0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tnsa_pkg::DIMS; i++) begin
        ext_r[i]  <= tnsa_pkg::EXT_W'(1);
        tile_r[i] <= tnsa_pkg::TILE_W'(1);
      end
    end else if (cfg_we) begin
      if (cfg_index < tnsa_pkg::CFG_TILE_0) begin
        ext_r[tnsa_pkg::DIM_W'(cfg_index - tnsa_pkg::CFG_EXT_0)] <= cfg_data;
      end else begin
        tile_r[tidx[tnsa_pkg::DIM_W-1:0]] <= cfg_data[tnsa_pkg::TILE_W-1:0];
      end
    end
  end

  always_comb begin
    zero_nxt = 1'b0;
    for (int i = 0; i < tnsa_pkg::DIMS; i++) begin
      if (ext_r[i] == '0 || tile_r[i] == '0) begin
        zero_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tnsa_pkg::DIMS; i++) begin
        oext_r[i] <= tnsa_pkg::OEXT_W'(1);
      end
      p23_r  <= tnsa_pkg::IDX_W'(1);
      str0_r <= tnsa_pkg::IDX_W'(1);
      zero_r <= 1'b0;
    end else begin
      zero_r <= zero_nxt;
      for (int i = 0; i < tnsa_pkg::DIMS; i++) begin
        oext_r[i] <= tnsa_pkg::OEXT_W'(ext_r[i]) * tnsa_pkg::OEXT_W'(tile_r[i]);
      end
      p23_r  <= tnsa_pkg::IDX_W'(ext_r[3]) * tnsa_pkg::IDX_W'(ext_r[2]);
      str0_r <= p23_r * tnsa_pkg::IDX_W'(ext_r[1]);
    end
  end

  assign stride[3] = tnsa_pkg::IDX_W'(1);
  assign stride[2] = tnsa_pkg::IDX_W'(ext_r[3]);
  assign stride[1] = p23_r;
  assign stride[0] = str0_r;

  for (genvar g = 0; g < NS; g++) begin : g_stg
    localparam int Dd  = g / tnsa_pkg::DIM_STG;
    localparam int K   = g % tnsa_pkg::DIM_STG;
    localparam int Dim = tnsa_pkg::DIMS - 1 - Dd;
    if (K < tnsa_pkg::DIV_STG) begin : g_div
      logic [tnsa_pkg::OEXT_W:0] tmp;
      logic [tnsa_pkg::OEXT_W:0] dif;
      logic                      ge;
      always_comb begin
        tmp = {s_r[g].rem, s_r[g].num[tnsa_pkg::IDX_W-1]};
        dif = tmp - {1'b0, oext_r[Dim]};
        ge  = tmp >= {1'b0, oext_r[Dim]};
        stg_nxt[g+1]     = s_r[g];
        stg_nxt[g+1].num = {s_r[g].num[tnsa_pkg::IDX_W-2:0], ge};
        stg_nxt[g+1].rem = ge ? dif[tnsa_pkg::OEXT_W-1:0] : tmp[tnsa_pkg::OEXT_W-1:0];
      end
    end else if (K < tnsa_pkg::DIV_STG + tnsa_pkg::MOD_STG) begin : g_mod
      localparam int Sh = tnsa_pkg::MOD_STG - 1 - (K - tnsa_pkg::DIV_STG);
      logic [tnsa_pkg::OEXT_W-1:0] shv;
      always_comb begin
        shv = tnsa_pkg::OEXT_W'(ext_r[Dim]) << Sh;
        stg_nxt[g+1] = s_r[g];
        if (s_r[g].rem >= shv) begin
          stg_nxt[g+1].rem = s_r[g].rem - shv;
        end
      end
    end else begin : g_mul
      logic [tnsa_pkg::EXT_W+tnsa_pkg::IDX_W-1:0] prod;
      always_comb begin
        prod = (tnsa_pkg::EXT_W + tnsa_pkg::IDX_W)'(s_r[g].rem[tnsa_pkg::EXT_W-1:0])
             * (tnsa_pkg::EXT_W + tnsa_pkg::IDX_W)'(stride[Dim]);
        stg_nxt[g+1]     = s_r[g];
        stg_nxt[g+1].off = s_r[g].off + prod[tnsa_pkg::IDX_W-1:0];
        stg_nxt[g+1].rem = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) begin
        s_r[i].vld <= 1'b0;
      end
    end else if (en) begin
      s_r[0] <= '{vld: in_valid, num: in_out_index, rem: '0, off: '0};
      for (int i = 1; i <= NS; i++) begin
        s_r[i] <= stg_nxt[i];
      end
    end
  end

  assign oor_nxt = zero_r || (s_r[NS].num != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s_r[NS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_oor_r <= oor_nxt;
      out_off_r <= oor_nxt ? '0 : s_r[NS].off;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_source_offset = out_off_r;
  assign out_out_of_range  = out_oor_r;

  `TNSA_ASSERT_NOW(a_oor_zero, out_valid_r && out_oor_r, out_off_r == '0)
  `TNSA_ASSERT_NEXT(a_last_to_out, s_r[NS].vld && en, out_valid_r)
  `TNSA_ASSERT_NEXT(a_hold_on_stall, out_valid_r && out_stall, out_valid_r && $stable(out_off_r))
endmodule
`default_nettype wire
